// ----- hw/rtl/rbir_pkg.sv -----
package rbir_pkg;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_ONLY_A     = 3'd1,
    ST_ONLY_B     = 3'd2,
    ST_SEPARATING = 3'd3,
    ST_RESOLVED   = 3'd4,
    ST_ZERO_MASS  = 3'd5
  } status_e;

  localparam logic CFG_SLOP = 1'b0;
  localparam logic CFG_CORR = 1'b1;

  localparam logic [16:0] SLOP_RESET = 17'd655;
  localparam logic [16:0] CORR_RESET = 17'd13107;

  // Bodies-present codes.
  localparam logic [1:0] PRESENT_NONE = 2'd0;
  localparam logic [1:0] PRESENT_A = 2'd1;
  localparam logic [1:0] PRESENT_B = 2'd2;
  localparam logic [1:0] PRESENT_AB = 2'd3;

  // Contact data that rides along with the quotients through the divider.
  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        ima;
    logic [30:0]        imb;
    logic signed [31:0] s;
    logic signed [31:0] dpx;
    logic signed [31:0] dpy;
    status_e            status;
  } pipe_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ----- hw/rtl/rbir_div.sv -----
module rbir_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [31:0] num_a_i,
  input  logic [30:0]        num_b_i,
  input  logic [31:0]        den_i,
  input  rbir_pkg::pipe_t    pay_i,
  output logic               vld_o,
  output logic [FRAC_BITS+31:0] quo_a_o,
  output logic [FRAC_BITS+31:0] quo_b_o,
  output rbir_pkg::pipe_t    pay_o
);

  localparam int NB = FRAC_BITS + 32;

  // Restoring division, one quotient bit per stage. The dividend shifts out of
  // the top of qa/qb while quotient bits shift in at the bottom.
  logic [31:0]     abs_a;
  logic [31:0]     rem_a_p [NB];
  logic [31:0]     rem_b_p [NB];
  logic [NB-1:0]   qa_p    [NB];
  logic [NB-1:0]   qb_p    [NB];
  logic [31:0]     den_p   [NB];
  logic [32:0]     sh_a    [NB];
  logic [32:0]     sh_b    [NB];
  logic            ge_a    [NB];
  logic            ge_b    [NB];
  logic [31:0]     rem_a_d [NB];
  logic [31:0]     rem_b_d [NB];
  logic [NB-1:0]   qa_d    [NB];
  logic [NB-1:0]   qb_d    [NB];

  logic [31:0]     rem_a_q [NB];
  logic [31:0]     rem_b_q [NB];
  logic [NB-1:0]   qa_q    [NB];
  logic [NB-1:0]   qb_q    [NB];
  logic [31:0]     den_q   [NB];
  rbir_pkg::pipe_t pay_q   [NB];
  logic [NB-1:0]   vld_q;

  assign abs_a = num_a_i[31] ? (~num_a_i + 32'd1) : num_a_i;

  always_comb begin
    rem_a_p[0] = '0;
    rem_b_p[0] = '0;
    qa_p[0]    = {abs_a, {FRAC_BITS{1'b0}}};
    qb_p[0]    = {1'b0, num_b_i, {FRAC_BITS{1'b0}}};
    den_p[0]   = den_i;
    for (int i = 1; i < NB; i++) begin
      rem_a_p[i] = rem_a_q[i-1];
      rem_b_p[i] = rem_b_q[i-1];
      qa_p[i]    = qa_q[i-1];
      qb_p[i]    = qb_q[i-1];
      den_p[i]   = den_q[i-1];
    end
    for (int i = 0; i < NB; i++) begin
      sh_a[i]    = {rem_a_p[i], qa_p[i][NB-1]};
      sh_b[i]    = {rem_b_p[i], qb_p[i][NB-1]};
      ge_a[i]    = sh_a[i] >= {1'b0, den_p[i]};
      ge_b[i]    = sh_b[i] >= {1'b0, den_p[i]};
      rem_a_d[i] = ge_a[i] ? 32'(sh_a[i] - {1'b0, den_p[i]}) : sh_a[i][31:0];
      rem_b_d[i] = ge_b[i] ? 32'(sh_b[i] - {1'b0, den_p[i]}) : sh_b[i][31:0];
      qa_d[i]    = {qa_p[i][NB-2:0], ge_a[i]};
      qb_d[i]    = {qb_p[i][NB-2:0], ge_b[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NB-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= pay_i;
      for (int i = 1; i < NB; i++) begin
        pay_q[i] <= pay_q[i-1];
      end
      for (int i = 0; i < NB; i++) begin
        rem_a_q[i] <= rem_a_d[i];
        rem_b_q[i] <= rem_b_d[i];
        qa_q[i]    <= qa_d[i];
        qb_q[i]    <= qb_d[i];
        den_q[i]   <= den_p[i];
      end
    end
  end

  assign vld_o   = vld_q[NB-1];
  assign quo_a_o = qa_q[NB-1];
  assign quo_b_o = qb_q[NB-1];
  assign pay_o   = pay_q[NB-1];

endmodule

// ----- hw/rtl/rigid_body_impulse_resolver.sv -----
// Impulse-based resolver for one 2D contact per beat, signed fixed point with
// FRAC_BITS fraction bits. Every arithmetic result saturates to 32 bits.
// Input stream: s_axis_* carries one contact per beat; tuser says which bodies
// are dynamic. Output stream: m_axis_* carries the velocity and position deltas
// of both bodies in tdata and the status code in tuser, one beat per contact,
// in input order.
// Configuration: cfg_we_i writes slop (index 0) or correction percent
// (index 1); write only while no contact is in flight.
// Throughput is one contact per cycle while the output is not stalled. The pipeline
// holds the restoring divider, which spends one stage on each of its 32 + FRAC_BITS
// quotient bits, plus twelve arithmetic stages.
// Reset clears all valid bits and loads the register defaults; no output beat
// appears until a contact has passed the whole pipeline.
// When the receiver holds tready low with a result waiting, the entire
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// While the output register is empty the pipeline keeps moving.
module rigid_body_impulse_resolver #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [16:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // normal_x, normal_y, penetration, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
  // restitution_a, restitution_b, inv_mass_a, inv_mass_b, one pad bit
  input  logic [319:0] s_axis_tdata,
  // bodies_present
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dvel_a_x, dvel_a_y, dvel_b_x, dvel_b_y, dpos_a_x, dpos_a_y, dpos_b_x, dpos_b_y
  output logic [255:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser
);

  localparam int NB = FRAC_BITS + 32;
  localparam logic [26:0] ONE_K = 27'(1) << FRAC_BITS;

  function automatic logic signed [64:0] flr(input logic signed [63:0] p);
    return 65'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] fmul(input logic signed [63:0] p);
    return rbir_pkg::sat32(flr(p));
  endfunction

  logic [16:0] slop_q, corr_q;
  logic        en;
  logic        out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slop_q <= rbir_pkg::SLOP_RESET;
      corr_q <= rbir_pkg::CORR_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rbir_pkg::CFG_SLOP) begin
        slop_q <= cfg_wdata_i;
      end else begin
        corr_q <= cfg_wdata_i;
      end
    end
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input field split.
  logic signed [31:0] in_nx, in_ny, in_vax, in_vay, in_vbx, in_vby;
  logic [30:0]        in_pen, in_ima, in_imb;
  logic [16:0]        in_ra, in_rb, rmin;
  logic [1:0]         in_pr;
  assign in_nx  = s_axis_tdata[31:0];
  assign in_ny  = s_axis_tdata[63:32];
  assign in_pen = s_axis_tdata[94:64];
  assign in_vax = s_axis_tdata[126:95];
  assign in_vay = s_axis_tdata[158:127];
  assign in_vbx = s_axis_tdata[190:159];
  assign in_vby = s_axis_tdata[222:191];
  assign in_ra  = s_axis_tdata[239:223];
  assign in_rb  = s_axis_tdata[256:240];
  assign in_ima = s_axis_tdata[287:257];
  assign in_imb = s_axis_tdata[318:288];
  assign in_pr  = s_axis_tuser;
  assign rmin   = (in_ra < in_rb) ? in_ra : in_rb;

  // Stage 1: pick the velocity, push and restitution factor for the case, and take the penetration beyond slop.
  logic signed [31:0] vx1_d, vy1_d, p1_d;
  logic signed [26:0] k1_d;
  logic [30:0]        ex1_d;
  always_comb begin
    unique case (in_pr)
      rbir_pkg::PRESENT_A: begin
        vx1_d = in_vax;
        vy1_d = in_vay;
        p1_d  = -$signed({1'b0, in_pen});
        k1_d  = $signed(ONE_K + 27'(in_ra));
      end
      rbir_pkg::PRESENT_B: begin
        vx1_d = in_vbx;
        vy1_d = in_vby;
        p1_d  = $signed({1'b0, in_pen});
        k1_d  = -$signed(ONE_K + 27'(in_rb));
      end
      default: begin
        vx1_d = rbir_pkg::sat32(65'(in_vbx) - 65'(in_vax));
        vy1_d = rbir_pkg::sat32(65'(in_vby) - 65'(in_vay));
        p1_d  = $signed({1'b0, in_pen});
        k1_d  = -$signed(ONE_K + 27'(rmin));
      end
    endcase
    ex1_d = (in_pen > 31'(slop_q)) ? (in_pen - 31'(slop_q)) : '0;
  end

  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [31:0] nx1_q, ny1_q, vx1_q, vy1_q, p1_q;
  logic signed [26:0] k1_q, k2_q, k3_q;
  logic [30:0]        ex1_q, ex2_q, ex3_q, ex4_q, ex5_q;
  logic [31:0]        sum1_q, sum2_q, sum3_q, sum4_q, sum5_q;
  logic [30:0]        ima1_q, imb1_q, ima2_q, imb2_q;
  logic [1:0]         pr1_q, pr2_q;
  logic signed [63:0] pdx2_q, pdy2_q, ppx2_q, ppy2_q;
  logic signed [31:0] nx2_q, ny2_q;
  logic signed [31:0] d3_q;
  logic signed [63:0] m4_q;
  rbir_pkg::pipe_t    pay3_q, pay4_q, pay5_q;

  // Stage 3 dot product and status.
  logic signed [31:0] d3_d;
  rbir_pkg::status_e  st3_d;
  assign d3_d = rbir_pkg::sat32(flr(pdx2_q) + flr(pdy2_q));
  always_comb begin
    unique case (pr2_q)
      rbir_pkg::PRESENT_A: st3_d = rbir_pkg::ST_ONLY_A;
      rbir_pkg::PRESENT_B: st3_d = rbir_pkg::ST_ONLY_B;
      rbir_pkg::PRESENT_AB: begin
        if (d3_d > 32'sd0) begin
          st3_d = rbir_pkg::ST_SEPARATING;
        end else if (sum2_q == '0) begin
          st3_d = rbir_pkg::ST_ZERO_MASS;
        end else begin
          st3_d = rbir_pkg::ST_RESOLVED;
        end
      end
      default: st3_d = rbir_pkg::ST_NONE;
    endcase
  end

  // Stage 5: the scaled dot product joins the carried contact data.
  rbir_pkg::pipe_t    pay5_d;
  always_comb begin
    pay5_d   = pay4_q;
    pay5_d.s = fmul(m4_q);
  end

  logic               vdv;
  logic [NB-1:0]      qa_dv, qb_dv;
  rbir_pkg::pipe_t    pay_dv;

  rbir_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (v5_q),
    .num_a_i (pay5_q.s),
    .num_b_i (ex5_q),
    .den_i   (sum5_q),
    .pay_i   (pay5_q),
    .vld_o   (vdv),
    .quo_a_o (qa_dv),
    .quo_b_o (qb_dv),
    .pay_o   (pay_dv)
  );

  // Stage 6: saturate the quotients; every case but a resolved pair takes s as the scale.
  logic signed [31:0] j6_d, q26_d;
  always_comb begin
    if (pay_dv.s[31]) begin
      if ((|qa_dv[NB-1:32]) || (qa_dv[31] && (|qa_dv[30:0]))) begin
        j6_d = 32'sh80000000;
      end else begin
        j6_d = -$signed(qa_dv[31:0]);
      end
    end else begin
      j6_d = (|qa_dv[NB-1:31]) ? 32'sh7fffffff : $signed(qa_dv[31:0]);
    end
    if (pay_dv.status != rbir_pkg::ST_RESOLVED) begin
      j6_d = pay_dv.s;
    end
    q26_d = (|qb_dv[NB-1:31]) ? 32'sh7fffffff : $signed(qb_dv[31:0]);
  end

  logic               v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic signed [31:0] j6_q, q26_q;
  logic signed [63:0] pjx7_q, pjy7_q, pc7_q, pcx9_q, pcy9_q;
  logic signed [31:0] ix8_q, iy8_q, c8_q, ix9_q, iy9_q, ix10_q, iy10_q, cx10_q, cy10_q;
  logic signed [31:0] ix11_q, iy11_q;
  logic signed [63:0] p11_q [8];
  rbir_pkg::pipe_t    pay6_q, pay7_q, pay8_q, pay9_q, pay10_q, pay11_q;

  logic signed [31:0] na10, pb10;
  assign na10 = -$signed({1'b0, pay10_q.ima});
  assign pb10 = $signed({1'b0, pay10_q.imb});

  // Stage 12: combine and place the results by status.
  logic [255:0] out_d;
  always_comb begin
    out_d = '0;
    unique case (pay11_q.status)
      rbir_pkg::ST_ONLY_A: begin
        out_d[31:0]    = ix11_q;
        out_d[63:32]   = iy11_q;
        out_d[159:128] = pay11_q.dpx;
        out_d[191:160] = pay11_q.dpy;
      end
      rbir_pkg::ST_ONLY_B: begin
        out_d[95:64]   = ix11_q;
        out_d[127:96]  = iy11_q;
        out_d[223:192] = pay11_q.dpx;
        out_d[255:224] = pay11_q.dpy;
      end
      rbir_pkg::ST_RESOLVED: begin
        for (int i = 0; i < 4; i++) begin
          out_d[32*i +: 32] = rbir_pkg::sat32(65'(fmul(p11_q[2*i]))
                                              + 65'(fmul(p11_q[2*i+1])));
        end
      end
      default: out_d = '0;
    endcase
  end

  logic [255:0] out_data_q;
  logic [2:0]   out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
      {v7_q, v8_q, v9_q, v10_q, v11_q, out_vld_q} <= '0;
    end else if (en) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= vdv;
      v7_q      <= v6_q;
      v8_q      <= v7_q;
      v9_q      <= v8_q;
      v10_q     <= v9_q;
      v11_q     <= v10_q;
      out_vld_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx1_q  <= in_nx;
      ny1_q  <= in_ny;
      vx1_q  <= vx1_d;
      vy1_q  <= vy1_d;
      p1_q   <= p1_d;
      k1_q   <= k1_d;
      ex1_q  <= ex1_d;
      sum1_q <= 32'(in_ima) + 32'(in_imb);
      ima1_q <= in_ima;
      imb1_q <= in_imb;
      pr1_q  <= in_pr;

      pdx2_q <= nx1_q * vx1_q;
      pdy2_q <= ny1_q * vy1_q;
      ppx2_q <= nx1_q * p1_q;
      ppy2_q <= ny1_q * p1_q;
      nx2_q  <= nx1_q;
      ny2_q  <= ny1_q;
      k2_q   <= k1_q;
      ex2_q  <= ex1_q;
      sum2_q <= sum1_q;
      ima2_q <= ima1_q;
      imb2_q <= imb1_q;
      pr2_q  <= pr1_q;

      d3_q          <= d3_d;
      k3_q          <= k2_q;
      ex3_q         <= ex2_q;
      sum3_q        <= sum2_q;
      pay3_q.nx     <= nx2_q;
      pay3_q.ny     <= ny2_q;
      pay3_q.ima    <= ima2_q;
      pay3_q.imb    <= imb2_q;
      pay3_q.s      <= '0;
      pay3_q.dpx    <= fmul(ppx2_q);
      pay3_q.dpy    <= fmul(ppy2_q);
      pay3_q.status <= st3_d;

      m4_q   <= 64'(d3_q) * 64'(k3_q);
      ex4_q  <= ex3_q;
      sum4_q <= sum3_q;
      pay4_q <= pay3_q;

      ex5_q  <= ex4_q;
      sum5_q <= sum4_q;
      pay5_q <= pay5_d;

      j6_q   <= j6_d;
      q26_q  <= q26_d;
      pay6_q <= pay_dv;

      pjx7_q <= pay6_q.nx * j6_q;
      pjy7_q <= pay6_q.ny * j6_q;
      pc7_q  <= 64'(q26_q) * 64'($signed({1'b0, corr_q}));
      pay7_q <= pay6_q;

      ix8_q  <= fmul(pjx7_q);
      iy8_q  <= fmul(pjy7_q);
      c8_q   <= fmul(pc7_q);
      pay8_q <= pay7_q;

      pcx9_q <= pay8_q.nx * c8_q;
      pcy9_q <= pay8_q.ny * c8_q;
      ix9_q  <= ix8_q;
      iy9_q  <= iy8_q;
      pay9_q <= pay8_q;

      cx10_q  <= fmul(pcx9_q);
      cy10_q  <= fmul(pcy9_q);
      ix10_q  <= ix9_q;
      iy10_q  <= iy9_q;
      pay10_q <= pay9_q;

      p11_q[0] <= ix10_q * na10;
      p11_q[1] <= cx10_q * na10;
      p11_q[2] <= iy10_q * na10;
      p11_q[3] <= cy10_q * na10;
      p11_q[4] <= ix10_q * pb10;
      p11_q[5] <= cx10_q * pb10;
      p11_q[6] <= iy10_q * pb10;
      p11_q[7] <= cy10_q * pb10;
      ix11_q   <= ix10_q;
      iy11_q   <= iy10_q;
      pay11_q  <= pay10_q;

      out_data_q <= out_d;
      out_st_q   <= pay11_q.status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_st_q;

endmodule

// ----- hw/rtl/rbir_checker.sv -----
module rbir_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  // Reset empties the pipeline by the next edge.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // Skipped contacts carry no deltas at all.
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == rbir_pkg::ST_NONE
      || m_axis_tuser == rbir_pkg::ST_SEPARATING
      || m_axis_tuser == rbir_pkg::ST_ZERO_MASS) |-> m_axis_tdata == '0)
    else $error("skipped contact has nonzero deltas");

  a_only_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == rbir_pkg::ST_ONLY_A
      |-> m_axis_tdata[127:64] == '0 && m_axis_tdata[255:192] == '0)
    else $error("body B moved in a single-body contact of A");

  a_resolved_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == rbir_pkg::ST_RESOLVED
      |-> m_axis_tdata[255:128] == '0)
    else $error("resolved pair has position deltas");

endmodule

bind rigid_body_impulse_resolver rbir_checker u_rbir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
